// File: sv/positional_list_engine_defines.svh
// Assertion macros for the positional list engine.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define PLE_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLE_ASSERT(lbl, ante, cons, msg)
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/ple_pkg.sv
package ple_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int VALUE_W_DEF  = 32;

    localparam int ACTION_W = 2;
    localparam int POS_W    = 9;
    localparam int ITEM_W   = 32;
    localparam int COUNT_W  = 9;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_INS_ALLOC,
        S_INS_POP,
        S_INS_NEXT,
        S_INS_SPLICE,
        S_INS_FIX,
        S_DEL_PREV,
        S_DEL_TGT,
        S_DEL_RD,
        S_DEL_UNLINK,
        S_DEL_FREE,
        S_RD,
        S_RD_DATA,
        S_DONE
    } state_t;

endpackage

// File: sv/ple_req_if.sv
interface ple_req_if import ple_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic [POS_W-1:0]          position;
    logic signed [ITEM_W-1:0]  value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink (input valid, input action, input position, input value,
                  output ready);
endinterface

// File: sv/ple_rsp_if.sv
interface ple_rsp_if import ple_pkg::*; ();
    logic                      valid;
    logic                      ready;
    status_t                   status;
    logic signed [ITEM_W-1:0]  item_value;
    logic [COUNT_W-1:0]        entry_count;

    modport source (output valid, output status, output item_value, output entry_count,
                    input ready);
    modport sink (input valid, input status, input item_value, input entry_count,
                  output ready);
endinterface

// File: sv/ple_ram.sv
module ple_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/positional_list_engine.sv
// A request that fails its checks goes straight to its result; a read, a delete or an insert
// first walks the list toward its position (an insert at position 1 needs no splice, and one
// that reuses a freed slot pops it off the free stack), and the result then waits for the sink.
// One request is taken at a time, the next only once the last result is in the output register;
// the walk follows one link per cycle. Reset clears the count, the head and the fill mark; the
// memories need no clearing pass, as slots beyond the mark are never read unwritten.
`include "positional_list_engine_defines.svh"

module positional_list_engine import ple_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input logic     clk,
    input logic     rst_n,
    ple_req_if.sink   req,
    ple_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t                  state_reg, state_next;
    logic [ACTION_W-1:0]     act_reg, act_next;
    logic                    first_reg, first_next;
    logic [VALUE_WIDTH-1:0]  val_reg, val_next;
    logic [AW-1:0]           cur_reg, cur_next;
    logic [AW-1:0]           slot_reg, slot_next;
    logic [AW-1:0]           steps_reg, steps_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [AW-1:0]           free_head_reg, free_head_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           hwm_reg, hwm_next;
    status_t                 stat_reg, stat_next;
    logic [VALUE_WIDTH-1:0]  res_reg, res_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [ITEM_W-1:0]       out_item_reg, out_item_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;

    logic                    link_we;
    logic [AW-1:0]           link_waddr, link_raddr, link_wdata, link_rdata;
    logic                    entry_we;
    logic [AW-1:0]           entry_raddr;
    logic [VALUE_WIDTH-1:0]  entry_rdata;

    logic [XW-1:0]           pos_x, cnt_x;
    logic [POS_W-1:0]        pos_m1, pos_m2;
    logic                    pos_zero, pos_first;
    logic                    ins_full, ins_bad, acc_empty, acc_bad;
    logic [AW-1:0]           steps_ins;
    logic [AW-1:0]           steps_rd;

    ple_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    ple_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_entry_ram (
        .clk   (clk),
        .we    (entry_we),
        .waddr (slot_reg),
        .wdata (val_reg),
        .raddr (entry_raddr),
        .rdata (entry_rdata)
    );

    // Position checks against the count held before the request.
    assign pos_x     = XW'(req.position);
    assign cnt_x     = XW'(count_reg);
    assign pos_m1    = req.position - POS_W'(1);
    assign pos_m2    = req.position - POS_W'(2);
    assign pos_zero  = (req.position == '0);
    assign pos_first = (req.position == POS_W'(1));
    assign ins_full  = (count_reg == CAP_C);
    assign ins_bad   = pos_zero || (pos_x > cnt_x + XW'(1));
    assign acc_empty = (count_reg == '0);
    assign acc_bad   = pos_zero || (pos_x > cnt_x);
    // Insert and delete stop at the entry before the position; both first and second need no walk.
    assign steps_ins = pos_first ? '0 : AW'(pos_m2);
    assign steps_rd  = AW'(pos_m1);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.item_value  = out_item_reg;
    assign rsp.entry_count = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        first_next      = first_reg;
        val_next        = val_reg;
        cur_next        = cur_reg;
        slot_next       = slot_reg;
        steps_next      = steps_reg;
        head_next       = head_reg;
        free_head_next  = free_head_reg;
        count_next      = count_reg;
        hwm_next        = hwm_reg;
        stat_next       = stat_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_item_next   = out_item_reg;
        out_count_next  = out_count_reg;
        link_we         = 1'b0;
        link_waddr      = slot_reg;
        link_wdata      = free_head_reg;
        link_raddr      = cur_reg;
        entry_we        = 1'b0;
        entry_raddr     = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                link_raddr = head_reg;
                if (req.valid)
                begin
                    act_next   = req.action;
                    first_next = pos_first;
                    val_next   = VALUE_WIDTH'($unsigned(req.value));
                    cur_next   = head_reg;
                    slot_next  = head_reg;
                    res_next   = '0;
                    stat_next  = ST_OK;
                    state_next = S_DONE;
                    case (req.action)
                        ACT_INSERT:
                        begin
                            if (ins_full)
                            begin
                                stat_next = ST_FULL;
                            end
                            else if (ins_bad)
                            begin
                                stat_next = ST_BAD_POS;
                            end
                            else
                            begin
                                steps_next = steps_ins;
                                state_next = (steps_ins == '0) ? S_INS_ALLOC : S_WALK;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (acc_empty)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else if (acc_bad)
                            begin
                                stat_next = ST_BAD_POS;
                            end
                            else
                            begin
                                steps_next = steps_ins;
                                if (steps_ins != '0)
                                begin
                                    state_next = S_WALK;
                                end
                                else
                                begin
                                    state_next = pos_first ? S_DEL_RD : S_DEL_PREV;
                                end
                            end
                        end
                        ACT_READ:
                        begin
                            if (acc_empty)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else if (acc_bad)
                            begin
                                stat_next = ST_BAD_POS;
                            end
                            else
                            begin
                                steps_next = steps_rd;
                                state_next = (steps_rd == '0) ? S_RD : S_WALK;
                            end
                        end
                        default:
                        begin
                            stat_next = ST_BAD_POS;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // The link read out this cycle names the next slot; chase it straight away.
                cur_next   = link_rdata;
                steps_next = steps_reg - AW'(1);
                link_raddr = link_rdata;
                if (steps_reg == AW'(1))
                begin
                    case (act_reg)
                        ACT_INSERT: state_next = S_INS_ALLOC;
                        ACT_DELETE: state_next = S_DEL_PREV;
                        default:    state_next = S_RD;
                    endcase
                end
            end

            S_INS_ALLOC:
            begin
                // Slots below the fill mark that are not in the list sit on the free stack.
                if (count_reg < hwm_reg)
                begin
                    slot_next  = free_head_reg;
                    link_raddr = free_head_reg;
                    state_next = S_INS_POP;
                end
                else
                begin
                    slot_next  = AW'(hwm_reg);
                    hwm_next   = hwm_reg + CW'(1);
                    state_next = S_INS_NEXT;
                end
            end

            S_INS_POP:
            begin
                free_head_next = link_rdata;
                state_next     = S_INS_NEXT;
            end

            S_INS_NEXT:
            begin
                if (first_reg)
                begin
                    link_we    = 1'b1;
                    link_wdata = head_reg;
                    entry_we   = 1'b1;
                    head_next  = slot_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    link_raddr = cur_reg;
                    state_next = S_INS_SPLICE;
                end
            end

            S_INS_SPLICE:
            begin
                link_we    = 1'b1;
                link_wdata = link_rdata;
                entry_we   = 1'b1;
                state_next = S_INS_FIX;
            end

            S_INS_FIX:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = slot_reg;
                state_next = S_DONE;
            end

            S_DEL_PREV:
            begin
                link_raddr = cur_reg;
                state_next = S_DEL_TGT;
            end

            S_DEL_TGT:
            begin
                slot_next   = link_rdata;
                link_raddr  = link_rdata;
                entry_raddr = link_rdata;
                state_next  = S_DEL_UNLINK;
            end

            S_DEL_RD:
            begin
                link_raddr  = slot_reg;
                entry_raddr = slot_reg;
                state_next  = S_DEL_UNLINK;
            end

            S_DEL_UNLINK:
            begin
                res_next = entry_rdata;
                if (first_reg)
                begin
                    head_next = link_rdata;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = cur_reg;
                    link_wdata = link_rdata;
                end
                state_next = S_DEL_FREE;
            end

            S_DEL_FREE:
            begin
                link_we        = 1'b1;
                link_wdata     = free_head_reg;
                free_head_next = slot_reg;
                state_next     = S_DONE;
            end

            S_RD:
            begin
                entry_raddr = cur_reg;
                state_next  = S_RD_DATA;
            end

            S_RD_DATA:
            begin
                res_next   = entry_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    if (stat_reg == ST_OK && act_reg == ACT_INSERT)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else if (stat_reg == ST_OK && act_reg == ACT_DELETE)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    out_valid_next  = 1'b1;
                    out_status_next = stat_reg;
                    out_item_next   = ITEM_W'(res_reg);
                    out_count_next  = COUNT_W'(count_next);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            hwm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            hwm_reg       <= hwm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        first_reg      <= first_next;
        val_reg        <= val_next;
        cur_reg        <= cur_next;
        slot_reg       <= slot_next;
        steps_reg      <= steps_next;
        free_head_reg  <= free_head_next;
        stat_reg       <= stat_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_item_reg   <= out_item_next;
        out_count_reg  <= out_count_next;
    end

    `PLE_ASSERT(a_count_bound, 1'b1, count_reg <= CAP_C, "entry count beyond capacity")
    `PLE_ASSERT(a_fill_mark, 1'b1, count_reg <= hwm_reg, "entry count above fill mark")
    `PLE_ASSERT(a_walk_steps, state_reg == S_WALK, steps_reg != '0, "walk with no steps left")
    `PLE_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_reg != S_IDLE, "request not taken up")
    `PLE_ASSERT_NEXT(a_count_hold, state_reg != S_DONE, $stable(count_reg), "count changed mid request")

endmodule
